// File: design/elias_code_length_totals_core_macros.svh
// Assertion macros shared by the Elias code length totals core.
`ifndef ELIAS_CODE_LENGTH_TOTALS_CORE_MACROS_SVH
`define ELIAS_CODE_LENGTH_TOTALS_CORE_MACROS_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define ECTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define ECTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ectl_pkg.sv
// Shared widths, constants and the queue item type of the Elias code length totals core.
package ectl_pkg;

  localparam int unsigned SYMBOL_BITS_DEF = 32;

  localparam int unsigned SymW     = 32;
  localparam int unsigned WeightW  = 32;
  localparam int unsigned ValW     = SymW + 1;
  localparam int unsigned BitLenW  = $clog2(ValW + 1);
  localparam int unsigned GLenW    = BitLenW + 1;
  localparam int unsigned DLenW    = 6;
  localparam int unsigned OLenW    = 6;
  localparam int unsigned TotalW   = 64;
  localparam int unsigned BytesPer = 8;
  localparam int unsigned ByteShift = $clog2(BytesPer);
  localparam int unsigned ByteW    = TotalW - ByteShift;
  localparam logic [ByteShift-1:0] RoundMask = ByteShift'(7);

  localparam int unsigned InTdataW  = ((SymW + WeightW + 7) / 8) * 8;
  localparam int unsigned OutFieldW = 3 * TotalW + 3 * ByteW;
  localparam int unsigned OutTdataW = ((OutFieldW + 7) / 8) * 8;
  localparam int unsigned OutPadW   = OutTdataW - OutFieldW;

  localparam int unsigned FifoDepth = 2;

  // One classified item on its way from the front to the back
  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [GLenW-1:0]   glen;
    logic [DLenW-1:0]   dlen;
    logic [OLenW-1:0]   olen;
    logic               last;
  } ectl_item_t;

endpackage

// File: design/ectl_front.sv
// Front end: takes input items and works out their gamma, delta and omega code lengths.
module ectl_front import ectl_pkg::*; #(
  parameter int unsigned SymbolBits = SYMBOL_BITS_DEF
) (
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [SymW-1:0]    symbol_i,
  input  logic [WeightW-1:0] weight_i,
  input  logic               last_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output ectl_item_t         push_item_o
);

  localparam int unsigned UsedBits = (SymbolBits < SymW) ? SymbolBits : SymW;
  localparam logic [SymW-1:0] SymMask = SymW'((65'(1) << UsedBits) - 65'(1));

  // Bit length of the coded value (priority encoder, highest set bit wins)
  function automatic logic [BitLenW-1:0] bit_len_val(input logic [ValW-1:0] v);
    logic [BitLenW-1:0] n;
    n = BitLenW'(1);
    for (int i = 0; i < ValW; i++) begin
      if (v[i]) n = BitLenW'(i + 1);
    end
    return n;
  endfunction

  // Bit length of a small value along the length chain
  function automatic logic [2:0] bit_len_small(input logic [BitLenW-1:0] x);
    logic [2:0] n;
    n = 3'd1;
    for (int i = 0; i < BitLenW; i++) begin
      if (x[i]) n = 3'(i + 1);
    end
    return n;
  endfunction

  // Omega length: 1 plus the lengths along x -> bitlen(x)-1 while x > 1
  function automatic logic [OLenW-1:0] omega_len(input logic [BitLenW-1:0] len);
    logic [OLenW-1:0]   tot;
    logic [BitLenW-1:0] x;
    logic [2:0]         n;
    tot = OLenW'(1);
    x   = '0;
    if (len >= BitLenW'(2)) begin
      tot = tot + OLenW'(len);
      x   = len - BitLenW'(1);
    end
    for (int k = 0; k < 4; k++) begin
      if (x > BitLenW'(1)) begin
        n   = bit_len_small(x);
        tot = tot + OLenW'(n);
        x   = BitLenW'(n) - BitLenW'(1);
      end
    end
    return tot;
  endfunction

  logic [ValW-1:0]    val;
  logic [BitLenW-1:0] len;
  logic [2:0]         len_len;

  // Coded value and its lengths
  always_comb begin
    val     = {1'b0, symbol_i & SymMask} + ValW'(1);
    len     = bit_len_val(val);
    len_len = bit_len_small(len);
    push_item_o.weight = weight_i;
    push_item_o.glen   = {len, 1'b0} - GLenW'(1);
    push_item_o.dlen   = DLenW'({len_len, 1'b0}) - DLenW'(1) + DLenW'(len) - DLenW'(1);
    push_item_o.olen   = omega_len(len);
    push_item_o.last   = last_i;
  end

  assign push_valid_o = s_valid_i;
  assign s_ready_o    = push_ready_i;

endmodule

// File: design/ectl_fifo.sv
// Short item queue between the front end and the back end.
module ectl_fifo import ectl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  ectl_item_t push_item_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output ectl_item_t pop_item_o
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  ectl_item_t          mem_q [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != CntW'(FifoDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: design/ectl_back.sv
// Back end: weights the code lengths, keeps the running totals and emits them on last.
module ectl_back import ectl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  ectl_item_t           pop_item_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [OutTdataW-1:0] m_data_o
);

  localparam int unsigned GProdW = WeightW + GLenW;
  localparam int unsigned DProdW = WeightW + DLenW;
  localparam int unsigned OProdW = WeightW + OLenW;

  // Multiply stage
  logic              mul_valid_q, mul_last_q;
  logic [GProdW-1:0] gprod_q;
  logic [DProdW-1:0] dprod_q;
  logic [OProdW-1:0] oprod_q;
  // Running totals
  logic [TotalW-1:0] gtot_q, dtot_q, otot_q;
  logic [TotalW-1:0] gsum, dsum, osum;
  // Emit stage
  logic              emit_valid_q;
  logic [TotalW-1:0] gemit_q, demit_q, oemit_q;
  // Output register
  logic              out_valid_q;
  logic [TotalW-1:0] gbits_q, dbits_q, obits_q;
  logic [ByteW-1:0]  gbytes_q, dbytes_q, obytes_q;

  logic out_load, emit_adv, emit_free, acc_en, mul_load;

  // Stall control, from the output back to the queue
  assign out_load    = !out_valid_q || m_ready_i;
  assign emit_adv    = emit_valid_q && out_load;
  assign emit_free   = !emit_valid_q || out_load;
  assign acc_en      = mul_valid_q && (!mul_last_q || emit_free);
  assign mul_load    = !mul_valid_q || acc_en;
  assign pop_ready_o = mul_load;

  assign gsum = gtot_q + TotalW'(gprod_q);
  assign dsum = dtot_q + TotalW'(dprod_q);
  assign osum = otot_q + TotalW'(oprod_q);

  // Byte count: ceil(bits/8), wrapping at the field width
  function automatic logic [ByteW-1:0] to_bytes(input logic [TotalW-1:0] bits);
    return ByteW'(bits >> ByteShift) + ByteW'((bits[ByteShift-1:0] & RoundMask) != '0);
  endfunction

  // Control and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q  <= 1'b0;
      emit_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      gtot_q       <= '0;
      dtot_q       <= '0;
      otot_q       <= '0;
    end else begin
      if (mul_load) begin
        mul_valid_q <= pop_valid_i;
      end
      emit_valid_q <= (acc_en && mul_last_q) || (emit_valid_q && !emit_adv);
      if (out_load) begin
        out_valid_q <= emit_valid_q;
      end
      if (acc_en) begin
        gtot_q <= mul_last_q ? '0 : gsum;
        dtot_q <= mul_last_q ? '0 : dsum;
        otot_q <= mul_last_q ? '0 : osum;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (mul_load) begin
      mul_last_q <= pop_item_i.last;
      gprod_q    <= GProdW'(pop_item_i.weight) * GProdW'(pop_item_i.glen);
      dprod_q    <= DProdW'(pop_item_i.weight) * DProdW'(pop_item_i.dlen);
      oprod_q    <= OProdW'(pop_item_i.weight) * OProdW'(pop_item_i.olen);
    end
    if (acc_en && mul_last_q) begin
      gemit_q <= gsum;
      demit_q <= dsum;
      oemit_q <= osum;
    end
    if (emit_adv) begin
      gbits_q  <= gemit_q;
      dbits_q  <= demit_q;
      obits_q  <= oemit_q;
      gbytes_q <= to_bytes(gemit_q);
      dbytes_q <= to_bytes(demit_q);
      obytes_q <= to_bytes(oemit_q);
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {OutPadW'(0), obytes_q, dbytes_q, gbytes_q, obits_q, dbits_q, gbits_q};

endmodule

// File: design/elias_code_length_totals_core.sv
// Top level of the Elias gamma/delta/omega code length totals core.
// Throughput: one item per cycle, set by the single multiply per code and the 64-bit add.
// It holds while m_axis_tready is high. A last item's totals pass through the queue,
// then the multiply, emit and output registers, waiting while m_axis_tready is low.
// Reset: rst_ni clears the queue, all valid flags and the three running totals at once.
`include "elias_code_length_totals_core_macros.svh"

module elias_code_length_totals_core import ectl_pkg::*; #(
  parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,  // [31:0] symbol, [63:32] weight
  input  logic                 s_axis_tlast,  // last
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [63:0] gamma_bits, [127:64] delta_bits, [191:128] omega_bits,
  // [252:192] gamma_bytes, [313:253] delta_bytes, [374:314] omega_bytes, [375] zero
  output logic [OutTdataW-1:0] m_axis_tdata
);

  logic       push_valid, push_ready;
  ectl_item_t push_item;
  logic       pop_valid, pop_ready;
  ectl_item_t pop_item;

  ectl_front #(
    .SymbolBits (SYMBOL_BITS)
  ) u_front (
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .symbol_i     (s_axis_tdata[SymW-1:0]),
    .weight_i     (s_axis_tdata[SymW+WeightW-1:SymW]),
    .last_i       (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  ectl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  ectl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

  // An accepted item is in the queue on the next cycle
  `ECTL_ASSERT_NEXT(a_accept_queued, s_axis_tvalid && s_axis_tready, pop_valid, "item not queued")
  // A queued item that is not taken stays queued
  `ECTL_ASSERT_NEXT(a_queue_holds, pop_valid && !pop_ready, pop_valid, "queued item lost")
  // The front only stalls while the queue holds items
  `ECTL_ASSERT_NOW(a_stall_full, !s_axis_tready, pop_valid, "front stalled on an empty queue")

endmodule
